FILE: design/bdp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// bdp_pkg
// Shared types, codes and helpers for the branch direction predictor.
// -----------------------------------------------------------------------------
package bdp_pkg;

   localparam int TABLE_ENTRIES_DEFAULT = 4096;
   localparam int QUEUE_DEPTH           = 2;
   localparam int QUEUE_PTR_W           = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W           = $clog2(QUEUE_DEPTH + 1);
   localparam int HIST_W                = 32;

   typedef logic [2:0] strategy_type;
   typedef logic [1:0] counter_type;

   localparam strategy_type STRAT_NEVER    = 3'd0;
   localparam strategy_type STRAT_ALWAYS   = 3'd1;
   localparam strategy_type STRAT_BACKWARD = 3'd2;
   localparam strategy_type STRAT_PC_TABLE = 3'd3;
   localparam strategy_type STRAT_GSH_32   = 3'd4;
   localparam strategy_type STRAT_GSH_16   = 3'd5;
   localparam strategy_type STRAT_GSH_8    = 3'd6;
   localparam strategy_type STRAT_GSH_4    = 3'd7;
   localparam strategy_type STRAT_RESET    = STRAT_PC_TABLE;

   localparam logic OP_PREDICT = 1'b0;
   localparam logic OP_UPDATE  = 1'b1;

   localparam counter_type CTR_STRONG_NT = 2'd0;
   localparam counter_type CTR_WEAK_T    = 2'd2;
   localparam counter_type CTR_STRONG_T  = 2'd3;

   typedef struct packed {
      logic is_update;
      logic use_table;
      logic static_taken;
      logic taken;
   } item_class_type;

   typedef struct packed {
      logic clearing;
      logic busy;
   } back_status_type;

   function automatic counter_type counter_step(input counter_type ctr, input logic taken);
      counter_type result;
      result = ctr;
      if (taken) begin
         if (ctr != CTR_STRONG_T) result = ctr + 2'd1;
      end else begin
         if (ctr != CTR_STRONG_NT) result = ctr - 2'd1;
      end
      return result;
   endfunction

endpackage
`default_nettype wire

FILE: design/branch_direction_predictor.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// branch_direction_predictor
// Branch direction predictor: static modes, a pc-indexed table of 2-bit
// counters, or gshare indexing with a 32, 16, 8 or 4 bit global history.
// -----------------------------------------------------------------------------
// Channel   Direction  Handshake         Payload
// req_      in         push / full       op, pc, branch_offset, taken
// rsp_      out        pop / empty       predict_taken
// csr_      in         valid / ready     strategy
//
// A request is registered in the front queue before the back can pop it. The
// back pops it in the idle state and registers its counter read; in the look
// state it writes the updated counter or loads the response register. The back
// takes no new request until it is back in the idle state. After reset a sweep
// sets every counter to weak taken; req_full stays high until it ends. csr_ready
// is always high. A response waiting in the output register stalls the back;
// the queue then fills and raises req_full.
// -----------------------------------------------------------------------------
module branch_direction_predictor #(
   parameter int TABLE_ENTRIES = bdp_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_push,
   output logic                       req_full,
   input  wire logic                  req_op,
   input  wire logic [31:0]           req_pc,
   input  wire logic signed [31:0]    req_branch_offset,
   input  wire logic                  req_taken,
   output logic                       rsp_empty,
   input  wire logic                  rsp_pop,
   output logic                       rsp_predict_taken,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire bdp_pkg::strategy_type csr_strategy
);
   import bdp_pkg::*;

   localparam int IDX_W  = $clog2(TABLE_ENTRIES);
   localparam int ITEM_W = $bits(item_class_type) + IDX_W;

   strategy_type    strategy_ff;
   item_class_type  f_class;
   logic [IDX_W-1:0] f_index;
   logic            f_push;
   logic            q_full;
   logic            q_empty;
   logic            q_pop;
   logic [ITEM_W-1:0] q_data;
   item_class_type  q_class;
   logic [IDX_W-1:0] q_index;
   back_status_type b_status;

   assign csr_ready = 1'b1;
   assign req_full  = q_full || b_status.clearing;
   assign f_push    = req_push && !req_full;
   assign q_class   = q_data[ITEM_W-1:IDX_W];
   assign q_index   = q_data[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         strategy_ff <= STRAT_RESET;
      end else if (csr_valid && csr_ready) begin
         strategy_ff <= csr_strategy;
      end
   end

   bdp_front #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_front (
      .clock             (clock),
      .reset             (reset),
      .strategy          (strategy_ff),
      .accept            (f_push),
      .req_op            (req_op),
      .req_pc            (req_pc),
      .req_branch_offset (req_branch_offset),
      .req_taken         (req_taken),
      .item_class        (f_class),
      .item_index        (f_index)
   );

   bdp_queue #(.DATA_W(ITEM_W)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_push),
      .push_data ({f_class, f_index}),
      .pop       (q_pop),
      .pop_data  (q_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   bdp_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_empty           (q_empty),
      .q_class           (q_class),
      .q_index           (q_index),
      .q_pop             (q_pop),
      .status            (b_status),
      .rsp_pop           (rsp_pop),
      .rsp_empty         (rsp_empty),
      .rsp_predict_taken (rsp_predict_taken)
   );

   a_no_push_while_clearing : assert property (@(posedge clock) disable iff (reset)
      b_status.clearing |-> !f_push)
      else $error("request entered the queue during the counter sweep");

   a_pop_only_when_idle : assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (!q_empty && !b_status.busy))
      else $error("back took a request while busy or from an empty queue");

   a_rsp_after_pop : assert property (@(posedge clock) disable iff (reset)
      ($rose(!rsp_empty)) |-> $past(b_status.busy))
      else $error("response appeared without a request in the back");

endmodule
`default_nettype wire

FILE: design/bdp_front.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// bdp_front
// Accepts requests, keeps the global history and works out the table index.
// -----------------------------------------------------------------------------
module bdp_front #(
   parameter int TABLE_ENTRIES = bdp_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire bdp_pkg::strategy_type        strategy,
   input  wire logic                         accept,
   input  wire logic                         req_op,
   input  wire logic [31:0]                  req_pc,
   input  wire logic signed [31:0]           req_branch_offset,
   input  wire logic                         req_taken,
   output bdp_pkg::item_class_type           item_class,
   output logic [$clog2(TABLE_ENTRIES)-1:0]  item_index
);
   import bdp_pkg::*;

   localparam int IDX_W = $clog2(TABLE_ENTRIES);

   logic [HIST_W-1:0] hist_ff;
   logic [HIST_W-1:0] hist_in;
   logic [HIST_W-1:0] hist_sel;
   logic [31:0]       hashed_pc;

   always_comb begin
      hist_in = hist_ff;
      if (accept && (req_op == OP_UPDATE)) begin
         hist_in = {hist_ff[HIST_W-2:0], req_taken};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff <= '0;
      end else begin
         hist_ff <= hist_in;
      end
   end

   always_comb begin
      case (strategy)
         STRAT_GSH_32: hist_sel = hist_ff;
         STRAT_GSH_16: hist_sel = {16'd0, hist_ff[15:0]};
         STRAT_GSH_8:  hist_sel = {24'd0, hist_ff[7:0]};
         STRAT_GSH_4:  hist_sel = {28'd0, hist_ff[3:0]};
         default:      hist_sel = '0;
      endcase
   end

   always_comb begin
      hashed_pc              = req_pc ^ hist_sel;
      item_class.is_update   = (req_op == OP_UPDATE);
      item_class.use_table   = (strategy inside {[STRAT_PC_TABLE:STRAT_GSH_4]});
      item_class.static_taken = (strategy == STRAT_ALWAYS) ||
                                ((strategy == STRAT_BACKWARD) && req_branch_offset[31]);
      item_class.taken       = req_taken;
      if (strategy inside {[STRAT_NEVER:STRAT_BACKWARD]}) begin
         item_index = '0;
      end else begin
         item_index = hashed_pc[IDX_W-1:0];
      end
   end

endmodule
`default_nettype wire

FILE: design/bdp_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// bdp_queue
// Short first-in first-out queue between the front and the back.
// -----------------------------------------------------------------------------
module bdp_queue #(
   parameter int DATA_W = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire logic [DATA_W-1:0] push_data,
   input  wire logic              pop,
   output logic [DATA_W-1:0]      pop_data,
   output logic                   full,
   output logic                   empty
);
   import bdp_pkg::*;

   logic [DATA_W-1:0]      slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff;
   logic [QUEUE_CNT_W-1:0] count_in;

   assign full     = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = rd_ptr_ff + 1'b1;
      if (push && !pop) count_in = count_ff + 1'b1;
      if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_data;
   end

endmodule
`default_nettype wire

FILE: design/bdp_back.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// bdp_back
// Counter memory, reset sweep, lookup and update, and the response register.
// -----------------------------------------------------------------------------
module bdp_back #(
   parameter int TABLE_ENTRIES = bdp_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               q_empty,
   input  wire bdp_pkg::item_class_type            q_class,
   input  wire logic [$clog2(TABLE_ENTRIES)-1:0]   q_index,
   output logic                                    q_pop,
   output bdp_pkg::back_status_type                status,
   input  wire logic                               rsp_pop,
   output logic                                    rsp_empty,
   output logic                                    rsp_predict_taken
);
   import bdp_pkg::*;

   localparam int IDX_W = $clog2(TABLE_ENTRIES);

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_LOOK  = 3'b100
   } state_type;

   state_type       state_ff;
   state_type       state_in;
   logic [IDX_W-1:0] clr_idx_ff;
   logic [IDX_W-1:0] clr_idx_in;
   item_class_type  item_ff;
   logic [IDX_W-1:0] index_ff;
   counter_type     rd_data_ff;
   counter_type     counter_mem_ff [TABLE_ENTRIES];
   logic            out_valid_ff;
   logic            out_valid_in;
   logic            out_taken_ff;
   logic            out_taken_in;
   logic            wr_en;
   logic [IDX_W-1:0] wr_addr;
   counter_type     wr_data;
   logic            slot_free;

   assign slot_free         = !out_valid_ff || rsp_pop;
   assign rsp_empty         = !out_valid_ff;
   assign rsp_predict_taken = out_taken_ff;
   assign status.clearing   = (state_ff == ST_CLEAR);
   assign status.busy       = (state_ff != ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      clr_idx_in   = clr_idx_ff;
      q_pop        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = index_ff;
      wr_data      = counter_step(rd_data_ff, item_ff.taken);
      out_valid_in = out_valid_ff && !rsp_pop;
      out_taken_in = out_taken_ff;
      case (state_ff)
         ST_CLEAR: begin
            wr_en      = 1'b1;
            wr_addr    = clr_idx_ff;
            wr_data    = CTR_WEAK_T;
            clr_idx_in = clr_idx_ff + 1'b1;
            if (clr_idx_ff == {IDX_W{1'b1}}) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (!q_empty && slot_free) begin
               q_pop    = 1'b1;
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            state_in = ST_IDLE;
            if (item_ff.is_update) begin
               wr_en = 1'b1;
            end else begin
               out_valid_in = 1'b1;
               out_taken_in = item_ff.use_table ? rd_data_ff[1] : item_ff.static_taken;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_idx_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_taken_ff <= out_taken_in;
      if (q_pop) begin
         item_ff  <= q_class;
         index_ff <= q_index;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) rd_data_ff <= counter_mem_ff[q_index];
   end

   always_ff @(posedge clock) begin
      if (wr_en) counter_mem_ff[wr_addr] <= wr_data;
   end

endmodule
`default_nettype wire

FILE: dv/bdp_checker.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// bdp_checker
// Watches the request, response and csr channels of the branch direction
// predictor, keeps its own copy of the counter table, global histories and
// strategy, and compares every response with the oldest predicted direction.
// -----------------------------------------------------------------------------
module bdp_checker #(
   parameter int TABLE_ENTRIES = bdp_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   input  logic                  req_full,
   input  logic                  req_op,
   input  logic [31:0]           req_pc,
   input  logic signed [31:0]    req_branch_offset,
   input  logic                  req_taken,
   input  logic                  rsp_empty,
   input  logic                  rsp_pop,
   input  logic                  rsp_predict_taken,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  bdp_pkg::strategy_type csr_strategy,
   output int                    failures,
   output int                    outstanding
);
   import bdp_pkg::*;

   localparam int IDX_W = $clog2(TABLE_ENTRIES);

   counter_type  pattern_table [TABLE_ENTRIES];
   logic [31:0]  ghist_32;
   logic [15:0]  ghist_16;
   logic [7:0]   ghist_8;
   logic [3:0]   ghist_4;
   strategy_type mode;
   logic         predicted_dirs [$];
   int           mismatches = 0;

   function automatic logic [IDX_W-1:0] table_slot(input logic [31:0] pc);
      logic [31:0] hist;
      case (mode)
         STRAT_NEVER, STRAT_ALWAYS, STRAT_BACKWARD: return '0;
         STRAT_GSH_32: hist = ghist_32;
         STRAT_GSH_16: hist = {16'd0, ghist_16};
         STRAT_GSH_8:  hist = {24'd0, ghist_8};
         STRAT_GSH_4:  hist = {28'd0, ghist_4};
         default:      hist = '0;
      endcase
      return IDX_W'(pc ^ hist);
   endfunction

   function automatic logic predict_direction(input logic [31:0] pc, input logic [31:0] offset);
      case (mode)
         STRAT_NEVER:    return 1'b0;
         STRAT_ALWAYS:   return 1'b1;
         STRAT_BACKWARD: return offset[31];
         default:        return pattern_table[table_slot(pc)][1];
      endcase
   endfunction

   task automatic train(input logic [31:0] pc, input logic outcome);
      logic [IDX_W-1:0] slot;
      counter_type      ctr;
      slot = table_slot(pc);
      ctr = pattern_table[slot];
      if (outcome && ctr != CTR_STRONG_T) begin
         ctr = ctr + 2'd1;
      end else if (!outcome && ctr != CTR_STRONG_NT) begin
         ctr = ctr - 2'd1;
      end
      pattern_table[slot] = ctr;
      ghist_32 = {ghist_32[30:0], outcome};
      ghist_16 = {ghist_16[14:0], outcome};
      ghist_8  = {ghist_8[6:0], outcome};
      ghist_4  = {ghist_4[2:0], outcome};
   endtask

   task automatic note_failure(input string what);
      mismatches++;
      if (mismatches <= 10) begin
         $display("bdp_checker: %s at %0t", what, $realtime);
      end
   endtask

   always @(posedge clock) begin
      logic want;
      if (reset) begin
         foreach (pattern_table[i]) pattern_table[i] = CTR_WEAK_T;
         ghist_32 = '0;
         ghist_16 = '0;
         ghist_8  = '0;
         ghist_4  = '0;
         mode = STRAT_RESET;
         predicted_dirs.delete();
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (predicted_dirs.size() == 0) begin
               note_failure($sformatf("response predict_taken=%0b with no request pending",
                                      rsp_predict_taken));
            end else begin
               want = predicted_dirs.pop_front();
               if (rsp_predict_taken !== want) begin
                  note_failure($sformatf("predict_taken expected %0b actual %0b",
                                         want, rsp_predict_taken));
               end
            end
         end
         if (req_push && !req_full) begin
            if (req_op == OP_PREDICT) begin
               predicted_dirs.push_back(predict_direction(req_pc, req_branch_offset));
            end else begin
               train(req_pc, req_taken);
            end
         end
         if (csr_valid && csr_ready) begin
            mode = csr_strategy;
         end
      end
      failures    <= mismatches;
      outstanding <= predicted_dirs.size();
   end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_top
// Drives the branch direction predictor through every strategy: a short
// directed sequence of corner cases, then phases of random branch traffic
// built from predict and update pairs over a small set of branch sites, with
// random gaps on the request side and random stalls on the response side.
// -----------------------------------------------------------------------------
module tb_top;
   import bdp_pkg::*;

   localparam int DRAIN_CYCLES  = 24;
   localparam int PHASE_ITEMS   = 130;
   localparam int RANDOM_PHASES = 12;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_push;
   logic         req_full;
   logic         req_op;
   logic [31:0]  req_pc;
   logic signed [31:0] req_branch_offset;
   logic         req_taken;
   logic         rsp_empty;
   logic         rsp_pop;
   logic         rsp_predict_taken;
   logic         csr_valid;
   logic         csr_ready;
   strategy_type csr_strategy;

   int           failures;
   int           outstanding;
   bit           sender_gaps     = 1'b1;
   bit           receiver_stalls = 1'b1;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   branch_direction_predictor DUT (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_op            (req_op),
      .req_pc            (req_pc),
      .req_branch_offset (req_branch_offset),
      .req_taken         (req_taken),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_predict_taken (rsp_predict_taken),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_strategy      (csr_strategy)
   );

   bdp_checker prediction_check (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_op            (req_op),
      .req_pc            (req_pc),
      .req_branch_offset (req_branch_offset),
      .req_taken         (req_taken),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_predict_taken (rsp_predict_taken),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_strategy      (csr_strategy),
      .failures          (failures),
      .outstanding       (outstanding)
   );

   task automatic send_request(input logic op, input logic [31:0] pc,
                               input logic [31:0] offset, input logic outcome);
      int gap;
      if (sender_gaps && $urandom_range(0, 7) == 0) begin
         req_push <= 1'b0;
         gap = $urandom_range(1, 17);
         repeat (gap) @(posedge clock);
      end
      req_push          <= 1'b1;
      req_op            <= op;
      req_pc            <= pc;
      req_branch_offset <= offset;
      req_taken         <= outcome;
      @(posedge clock);
      while (req_full) @(posedge clock);
   endtask

   task automatic drain_pipeline();
      req_push <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_strategy(input strategy_type mode);
      csr_valid    <= 1'b1;
      csr_strategy <= mode;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(input int budget);
      logic [31:0] site   [8];
      logic        lean   [8];
      int          period [8];
      int          visits [8];
      int          sent;
      int          k;
      int          pick;
      logic        outcome;
      foreach (site[i]) begin
         site[i]   = $urandom();
         lean[i]   = 1'($urandom_range(0, 1));
         period[i] = $urandom_range(2, 9);
         visits[i] = 0;
      end
      // Two sites alias in the counter table to exercise shared entries.
      site[7][11:0] = site[6][11:0];
      sent = 0;
      while (sent < budget) begin
         pick = $urandom_range(0, 9);
         k = $urandom_range(0, 7);
         if (pick < 7) begin
            outcome = (visits[k] % period[k] == period[k] - 1) ? !lean[k] : lean[k];
            visits[k]++;
            send_request(OP_PREDICT, site[k], $urandom(), 1'($urandom_range(0, 1)));
            send_request(OP_UPDATE, site[k], $urandom(), outcome);
            sent += 2;
         end else if (pick == 7) begin
            send_request(OP_PREDICT, $urandom(), $urandom(), 1'($urandom_range(0, 1)));
            sent++;
         end else if (pick == 8) begin
            send_request(OP_UPDATE, $urandom(), $urandom(), 1'($urandom_range(0, 1)));
            sent++;
         end else begin
            repeat ($urandom_range(2, 5)) begin
               send_request(OP_PREDICT, site[k], $urandom(), 1'($urandom_range(0, 1)));
               sent++;
            end
         end
      end
   endtask

   initial begin : response_sink
      int stall;
      rsp_pop <= 1'b0;
      @(posedge clock);
      forever begin
         if (receiver_stalls && $urandom_range(0, 7) == 0) begin
            rsp_pop <= 1'b0;
            stall = $urandom_range(1, 17);
            repeat (stall) @(posedge clock);
         end else begin
            rsp_pop <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      strategy_type plan [RANDOM_PHASES];
      plan = '{STRAT_GSH_32, STRAT_NEVER, STRAT_GSH_4, STRAT_BACKWARD, STRAT_GSH_16,
               STRAT_ALWAYS, STRAT_GSH_8, STRAT_PC_TABLE, STRAT_GSH_4, STRAT_NEVER,
               STRAT_PC_TABLE, STRAT_GSH_32};
      for (int i = 8; i < RANDOM_PHASES - 1; i++) begin
         plan[i] = strategy_type'($urandom_range(0, 7));
      end
      reset             <= 1'b1;
      req_push          <= 1'b0;
      req_op            <= OP_PREDICT;
      req_pc            <= '0;
      req_branch_offset <= '0;
      req_taken         <= 1'b0;
      csr_valid         <= 1'b0;
      csr_strategy      <= STRAT_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Fresh counters predict taken; walk one entry down and another to saturation.
      write_strategy(STRAT_PC_TABLE);
      send_request(OP_PREDICT, 32'h0000_0000, 32'h0000_0000, 1'b1);
      send_request(OP_PREDICT, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0);
      send_request(OP_UPDATE,  32'h0000_0000, 32'h0000_0000, 1'b0);
      send_request(OP_UPDATE,  32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
      send_request(OP_PREDICT, 32'h0000_0000, 32'h8000_0000, 1'b1);
      send_request(OP_UPDATE,  32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
      send_request(OP_UPDATE,  32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
      send_request(OP_PREDICT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
      drain_pipeline();

      // Static modes train entry zero whatever the pc.
      write_strategy(STRAT_NEVER);
      send_request(OP_PREDICT, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1);
      send_request(OP_UPDATE,  32'h0000_0123, 32'h8000_0000, 1'b1);
      send_request(OP_UPDATE,  32'h0000_0123, 32'h7FFF_FFFF, 1'b1);
      drain_pipeline();
      write_strategy(STRAT_ALWAYS);
      send_request(OP_PREDICT, 32'h0000_0000, 32'h0000_0000, 1'b0);
      send_request(OP_UPDATE,  32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
      drain_pipeline();
      write_strategy(STRAT_BACKWARD);
      send_request(OP_PREDICT, 32'h0000_1000, 32'h8000_0000, 1'b0);
      send_request(OP_PREDICT, 32'h0000_1000, 32'h7FFF_FFFF, 1'b1);
      send_request(OP_PREDICT, 32'h0000_1000, 32'hFFFF_FFFF, 1'b0);
      send_request(OP_PREDICT, 32'h0000_1000, 32'h0000_0000, 1'b1);
      send_request(OP_UPDATE,  32'h0000_1000, 32'h8000_0000, 1'b1);
      drain_pipeline();

      // Global history folds into the index.
      write_strategy(STRAT_GSH_4);
      send_request(OP_PREDICT, 32'h0000_0000, 32'h0000_0000, 1'b0);
      send_request(OP_UPDATE,  32'h0000_0005, 32'h0000_0000, 1'b1);
      send_request(OP_PREDICT, 32'h0000_0001, 32'h0000_0000, 1'b0);
      drain_pipeline();
      write_strategy(STRAT_GSH_32);
      send_request(OP_PREDICT, 32'h0000_0000, 32'h0000_0000, 1'b0);
      send_request(OP_UPDATE,  32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
      send_request(OP_PREDICT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
      drain_pipeline();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p == RANDOM_PHASES - 1) begin
            sender_gaps     = 1'b0;
            receiver_stalls = 1'b0;
         end
         write_strategy(plan[p]);
         run_phase(PHASE_ITEMS);
         drain_pipeline();
      end

      if (failures == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

   initial begin : watchdog
      #(5_000_000);
      $display("tb_top: errors");
      $finish;
   end

endmodule
